// ===== hw/rtl/alxg_pkg.sv =====
// ----------------------------------------------------------------------------
// alxg_pkg
// Shared types, widths and command codes for the argmax-label cross-entropy
// loss and gradient block.
// ----------------------------------------------------------------------------
`default_nettype none

package alxg_pkg;

    localparam int MAX_CLASSES = 8;
    localparam int IDX_W       = $clog2(MAX_CLASSES);
    localparam int CNT_W       = $clog2(MAX_CLASSES + 1);

    localparam int VAL_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int SUM_W       = 48;
    localparam int DIV_W       = 48;
    localparam int DIV_CNT_W   = 6;
    localparam int LOG_STEPS   = 16;
    localparam int LN_W        = 23;

    localparam logic [CFG_IDX_W-1:0] CFG_NORM_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_WEIGHT = 2'd3;

    localparam logic [1:0] NORM_FULL  = 2'd0;
    localparam logic [1:0] NORM_VALID = 2'd1;
    localparam logic [1:0] NORM_BATCH = 2'd2;
    localparam logic [1:0] NORM_NONE  = 2'd3;

    localparam logic [VAL_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [31:0]      LN2_Q32 = 32'd2977044472;

    typedef logic [3:0] t_op;

    localparam t_op OP_NONE     = 4'd0;
    localparam t_op OP_ACCEPT   = 4'd1;
    localparam t_op OP_RD_BEST  = 4'd2;
    localparam t_op OP_LOG_INIT = 4'd3;
    localparam t_op OP_LOG_STEP = 4'd4;
    localparam t_op OP_LN       = 4'd5;
    localparam t_op OP_SUM      = 4'd6;
    localparam t_op OP_RD_K     = 4'd7;
    localparam t_op OP_MUL      = 4'd8;
    localparam t_op OP_START    = 4'd9;
    localparam t_op OP_EMIT     = 4'd10;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] k;
        logic             kind;   // 1 while working on the final loss
        logic             last;
        logic             done;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic             div_done;
        logic             out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/argmax_label_xent_loss_grad.sv =====
// The last class word of a position runs accept, buffer read, log set-up, 16
// squarings, ln scale, sum; others are just accepted. Each gradient reads,
// multiplies, starts the shared 48-step restoring divider (one quotient bit a
// cycle), waits, emits; after the last position so does the final loss, but
// for the read. Emits wait out output stalls. Synchronous active-low reset
// sets register defaults, clears control state; the buffer is not reset.
// ----------------------------------------------------------------------------
// argmax_label_xent_loss_grad
// Cross-entropy loss and gradient against the argmax of a soft label, Q16.
// ----------------------------------------------------------------------------
`default_nettype none

module argmax_label_xent_loss_grad
    import alxg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [16:0]           i_label_value,
    input  wire logic [16:0]           i_prob_value,
    input  wire logic                  i_last_class,
    input  wire logic                  i_last_position,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_result_kind,
    output logic [5:0]                 o_class_index,
    output logic signed [31:0]         o_result_value,
    output logic                       o_last
);

    t_cmd  cmd;
    t_stat stat;

    alxg_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_last_class    (i_last_class),
        .i_last_position (i_last_position),
        .i_stat          (stat),
        .o_in_stall      (o_in_stall),
        .o_cmd           (cmd)
    );

    alxg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_label_value  (i_label_value),
        .i_prob_value   (i_prob_value),
        .i_out_stall    (i_out_stall),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_result_kind  (o_result_kind),
        .o_class_index  (o_class_index),
        .o_result_value (o_result_value),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/alxg_div.sv =====
// ----------------------------------------------------------------------------
// alxg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module alxg_div
    import alxg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DIV_W-1:0] o_quot
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]     r_rem, n_rem;
    logic [DIV_W-1:0]     r_dvd, n_dvd;
    logic [DIV_W-1:0]     r_dvs, n_dvs;
    logic [DIV_W:0]       trial;
    logic                 qbit;

    always_comb begin
        trial  = {r_rem, r_dvd[DIV_W-1]};
        qbit   = (trial >= {1'b0, r_dvs});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_W);
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = qbit ? DIV_W'(trial - {1'b0, r_dvs}) : trial[DIV_W-1:0];
            n_dvd = {r_dvd[DIV_W-2:0], qbit};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

`default_nettype wire

// ===== hw/rtl/alxg_dp.sv =====
// ----------------------------------------------------------------------------
// alxg_dp
// Datapath: configuration registers, probability buffer, argmax tracking,
// log unit, loss accumulator, gradient and loss division, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module alxg_dp
    import alxg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [VAL_W-1:0]      i_label_value,
    input  wire logic [VAL_W-1:0]      i_prob_value,
    input  wire logic                  i_out_stall,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    output logic                       o_out_valid,
    output logic                       o_result_kind,
    output logic [5:0]                 o_class_index,
    output logic signed [31:0]         o_result_value,
    output logic                       o_last
);

    logic [1:0]        r_norm_mode;
    logic [15:0]       r_outer, r_inner;
    logic [VAL_W-1:0]  r_lw;

    logic [VAL_W-1:0]  r_best_label;
    logic [IDX_W-1:0]  r_best_class;
    logic [CNT_W-1:0]  r_count;
    logic [VAL_W-1:0]  mem [MAX_CLASSES];
    logic [VAL_W-1:0]  r_rd;
    logic [IDX_W-1:0]  rd_addr;

    logic [4:0]        r_exp;
    logic [30:0]       r_mant;
    logic [15:0]       r_frac;
    logic signed [LN_W-1:0] r_ln;
    logic signed [SUM_W-1:0] r_sum;
    logic [31:0]       r_pos;
    logic [31:0]       r_full;

    logic [DIV_W-1:0]  r_num;
    logic              r_neg;

    logic              r_out_valid;
    logic              r_kind;
    logic [5:0]        r_cls;
    logic [31:0]       r_val;
    logic              r_last;

    // log unit
    logic [VAL_W-1:0]  x;
    logic [4:0]        msb;
    logic [61:0]       sq;
    logic [31:0]       sq_t;
    logic [20:0]       l_q16;
    logic [20:0]       d_ln;
    logic              ln_neg;
    logic [52:0]       ln_prod;
    logic [20:0]       ln_mag;

    logic signed [SUM_W:0] sum_ext;
    logic [31:0]       g_norm, l_norm;
    logic [VAL_W-1:0]  diff_mag;
    logic              diff_neg;
    logic              hot;
    logic [33:0]       prod;
    logic [DIV_W-1:0]  sum_mag;
    logic [DIV_W-1:0]  dividend, divisor;
    logic              div_done;
    logic [DIV_W-1:0]  quot;
    logic [31:0]       q_val;
    logic              out_free;
    logic              start;

    always_comb begin
        x   = (r_rd == '0) ? VAL_W'(1) : r_rd;
        msb = '0;
        for (int i = 0; i < VAL_W; i++) begin
            if (x[i]) msb = 5'(i);
        end
        sq    = r_mant * r_mant;
        sq_t  = sq[61:30];
        l_q16 = {r_exp, r_frac};
        ln_neg = (l_q16 > 21'd1048576);
        d_ln   = ln_neg ? (l_q16 - 21'd1048576) : (21'd1048576 - l_q16);
        ln_prod = d_ln * LN2_Q32 + 53'd2147483648;
        ln_mag  = ln_prod[52:32];
    end

    always_comb begin
        sum_ext = {r_sum[SUM_W-1], r_sum} + (SUM_W+1)'(r_ln);
        case (r_norm_mode)
            NORM_FULL, NORM_VALID: g_norm = (r_full == '0) ? 32'd1 : r_full;
            NORM_BATCH: g_norm = (r_outer == '0) ? 32'd1 : {16'd0, r_outer};
            default:    g_norm = 32'd1;
        endcase
        case (r_norm_mode)
            NORM_FULL:  l_norm = (r_full == '0) ? 32'd1 : r_full;
            NORM_VALID: l_norm = (r_pos == '0) ? 32'd1 : r_pos;
            NORM_BATCH: l_norm = (r_outer == '0) ? 32'd1 : {16'd0, r_outer};
            default:    l_norm = 32'd1;
        endcase
        hot      = (i_cmd.k == r_best_class);
        diff_neg = hot && (r_rd < ONE_Q16);
        if (!hot)          diff_mag = r_rd;
        else if (diff_neg) diff_mag = ONE_Q16 - r_rd;
        else               diff_mag = r_rd - ONE_Q16;
        prod    = diff_mag * r_lw;
        sum_mag = r_sum[SUM_W-1] ? DIV_W'(-r_sum) : DIV_W'(r_sum);
        if (i_cmd.kind) begin
            dividend = r_num + DIV_W'(l_norm >> 1);
            divisor  = DIV_W'(l_norm);
        end else begin
            dividend = r_num + (DIV_W'(g_norm) << 15);
            divisor  = DIV_W'(g_norm) << 16;
        end
        q_val = r_neg ? (32'd0 - quot[31:0]) : quot[31:0];
        rd_addr = (i_cmd.op == OP_RD_BEST) ? r_best_class : i_cmd.k;
        start   = (i_cmd.op == OP_START);
        out_free = !r_out_valid || !i_out_stall;
    end

    alxg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Buffer: no reset, every read hits an entry written in the same position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ACCEPT && r_count < CNT_W'(MAX_CLASSES)) begin
            mem[r_count[IDX_W-1:0]] <= i_prob_value;
        end
        if (i_cmd.op == OP_RD_BEST || i_cmd.op == OP_RD_K) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_mode  <= NORM_VALID;
            r_outer      <= 16'd1;
            r_inner      <= 16'd1;
            r_lw         <= ONE_Q16;
            r_best_label <= '0;
            r_best_class <= '0;
            r_count      <= '0;
            r_sum        <= '0;
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NORM_MODE:   r_norm_mode <= i_cfg_data[1:0];
                    CFG_OUTER_COUNT: r_outer     <= i_cfg_data[15:0];
                    CFG_INNER_COUNT: r_inner     <= i_cfg_data[15:0];
                    CFG_LOSS_WEIGHT: r_lw        <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_ACCEPT && r_count < CNT_W'(MAX_CLASSES)) begin
                if (i_label_value > r_best_label) begin
                    r_best_label <= i_label_value;
                    r_best_class <= r_count[IDX_W-1:0];
                end
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.op == OP_SUM) begin
                if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
                    r_sum <= sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                            : {1'b0, {(SUM_W-1){1'b1}}};
                end else begin
                    r_sum <= sum_ext[SUM_W-1:0];
                end
                if (r_pos != '1) r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
                if (i_cmd.done) begin
                    r_best_label <= '0;
                    r_best_class <= '0;
                    r_count      <= '0;
                    if (i_cmd.kind) begin
                        r_sum <= '0;
                        r_pos <= '0;
                    end
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOG_INIT: begin
                r_exp  <= msb;
                r_mant <= 31'(x) << (5'd30 - msb);
                r_frac <= '0;
            end
            OP_LOG_STEP: begin
                r_mant <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                r_frac <= {r_frac[14:0], sq_t[31]};
            end
            OP_LN: begin
                r_ln <= ln_neg ? -LN_W'(ln_mag) : LN_W'(ln_mag);
            end
            OP_SUM: begin
                r_full <= r_outer * r_inner;
            end
            OP_MUL: begin
                if (i_cmd.kind) begin
                    r_num <= sum_mag;
                    r_neg <= r_sum[SUM_W-1];
                end else begin
                    r_num <= DIV_W'(prod);
                    r_neg <= diff_neg;
                end
            end
            OP_EMIT: begin
                r_kind <= i_cmd.kind;
                r_last <= i_cmd.last;
                if (i_cmd.kind) begin
                    r_cls <= '0;
                    if (quot > DIV_W'(32'h7FFFFFFF) + DIV_W'(r_neg)) begin
                        r_val <= r_neg ? 32'h80000000 : 32'h7FFFFFFF;
                    end else begin
                        r_val <= q_val;
                    end
                end else begin
                    r_cls <= 6'(i_cmd.k);
                    r_val <= q_val;
                end
            end
            default: ;
        endcase
    end

    assign o_stat.n        = r_count;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_class_index  = r_cls;
    assign o_result_value = r_val;
    assign o_last         = r_last;

endmodule

`default_nettype wire

// ===== hw/rtl/alxg_ctrl.sv =====
// ----------------------------------------------------------------------------
// alxg_ctrl
// Sequencer: takes class words, runs the log iterations, then one division
// per gradient and, after the last position, one for the final loss.
// ----------------------------------------------------------------------------
`default_nettype none

module alxg_ctrl
    import alxg_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_last_class,
    input  wire logic  i_last_position,
    input  wire t_stat i_stat,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RD_BEST  = 4'd1;
    localparam logic [3:0] S_LOG_INIT = 4'd2;
    localparam logic [3:0] S_LOG_STEP = 4'd3;
    localparam logic [3:0] S_LN       = 4'd4;
    localparam logic [3:0] S_SUM      = 4'd5;
    localparam logic [3:0] S_RD_K     = 4'd6;
    localparam logic [3:0] S_MUL      = 4'd7;
    localparam logic [3:0] S_START    = 4'd8;
    localparam logic [3:0] S_DIV      = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [3:0]       r_iter, n_iter;
    logic [IDX_W-1:0] r_k, n_k;
    logic             r_lp, n_lp;
    logic             r_kind, n_kind;
    logic             grad_end;

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        n_k     = r_k;
        n_lp    = r_lp;
        n_kind  = r_kind;
        grad_end = ((CNT_W'(r_k) + 1'b1) == i_stat.n);
        o_cmd.op   = OP_NONE;
        o_cmd.k    = r_k;
        o_cmd.kind = r_kind;
        o_cmd.last = r_kind || (grad_end && !r_lp);
        o_cmd.done = r_kind || (grad_end && !r_lp);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    if (i_last_class) begin
                        n_lp    = i_last_position;
                        n_state = S_RD_BEST;
                    end
                end
            end
            S_RD_BEST: begin
                o_cmd.op = OP_RD_BEST;
                n_state  = S_LOG_INIT;
            end
            S_LOG_INIT: begin
                o_cmd.op = OP_LOG_INIT;
                n_iter   = '0;
                n_state  = S_LOG_STEP;
            end
            S_LOG_STEP: begin
                o_cmd.op = OP_LOG_STEP;
                n_iter   = r_iter + 1'b1;
                if (r_iter == 4'(LOG_STEPS - 1)) n_state = S_LN;
            end
            S_LN: begin
                o_cmd.op = OP_LN;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                n_k      = '0;
                n_kind   = 1'b0;
                n_state  = S_RD_K;
            end
            S_RD_K: begin
                o_cmd.op = OP_RD_K;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_START;
            end
            S_START: begin
                o_cmd.op = OP_START;
                n_state  = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT;
                    if (r_kind) begin
                        n_state = S_IDLE;
                    end else if (!grad_end) begin
                        n_k     = r_k + 1'b1;
                        n_state = S_RD_K;
                    end else if (r_lp) begin
                        n_kind  = 1'b1;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
            r_k     <= '0;
            r_lp    <= 1'b0;
            r_kind  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_k     <= n_k;
            r_lp    <= n_lp;
            r_kind  <= n_kind;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire
